/* hw/rtl/adv_pattern_classifier_tracker_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the advertisement pattern classifier and tracker
// Shared property forms; every use samples on clock and is masked by reset.
// ----------------------------------------------------------------------------
`ifndef ADV_PATTERN_CLASSIFIER_TRACKER_CORE_MACROS_SVH
`define ADV_PATTERN_CLASSIFIER_TRACKER_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define APCT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define APCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/apct_pkg.sv */
// ----------------------------------------------------------------------------
// apct_pkg
// Types, constants and pattern tables of the advertisement classifier/tracker.
// ----------------------------------------------------------------------------
package apct_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int PATTERN_COUNT = 9;
   localparam int PATTERN_BYTES = 16;
   localparam int MATCH_LEN     = 15;

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
   localparam int PB_W    = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
   localparam int KIND_W  = 4;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;
   localparam int POS_W   = 8;

   localparam logic [31:0] AGE_RESET = 32'd15000;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_REFRESH = 2'd1,
      ACT_INSERT  = 2'd2,
      ACT_DROP    = 2'd3
   } action_type;

   typedef struct packed {
      logic              mode;
      logic [7:0]        data_byte;
      logic              last;
      logic [47:0]       address;
      logic signed [7:0] signal_strength;
      logic [31:0]       now_ms;
   } req_type;

   typedef struct packed {
      logic               matched;
      logic [KIND_W-1:0]  kind;
      action_type         action;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] removed;
      logic [COUNT_W-1:0] occupancy;
   } rsp_type;

   // One table entry as held in the entry memory.
   typedef struct packed {
      logic [47:0]       address;
      logic [31:0]       seen;
      logic signed [7:0] strength;
      logic [KIND_W-1:0] kind;
   } entry_type;

   typedef logic [0:PATTERN_BYTES-1][7:0] pat_row_type;

   // Bit i set means byte i must equal the pattern byte.
   localparam logic [PATTERN_BYTES-1:0] PAT_CARE [PATTERN_COUNT] = '{
      16'h101F, 16'h001F, 16'h001F, 16'h77FF, 16'h0003,
      16'h7FFF, 16'h0FFF, 16'h001F, 16'h03FF
   };

   localparam pat_row_type PAT_DATA [PATTERN_COUNT] = '{
      '{8'h4c, 8'h00, 8'h07, 8'h19, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h4c, 8'h00, 8'h0f, 8'h05, 8'hc0, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h4c, 8'h00, 8'h07, 8'h19, 8'h07, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h4c, 8'h00, 8'h04, 8'h04, 8'h2a, 8'h00, 8'h00, 8'h00,
        8'h0f, 8'h05, 8'hc1, 8'h00, 8'h60, 8'h4c, 8'h95, 8'h00},
      '{8'h2c, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h75, 8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h01, 8'h01,
        8'hff, 8'h00, 8'h00, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h06, 8'h00, 8'h03, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hff, 8'h00, 8'h6d, 8'hb6, 8'h43, 8'hce, 8'h97, 8'hfe,
        8'h42, 8'h7c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   // Clears the live bit of every pattern that the byte at this position misses, below MATCH_LEN.
   function automatic logic [PATTERN_COUNT-1:0] alive_update(
      input logic [PATTERN_COUNT-1:0] alive,
      input logic [POS_W-1:0]         pos,
      input logic [7:0]               data
   );
      logic [PATTERN_COUNT-1:0] res;
      logic [PB_W-1:0]          idx;
      res = alive;
      idx = pos[PB_W-1:0];
      if (int'(pos) < MATCH_LEN && int'(pos) < PATTERN_BYTES) begin
         for (int k = 0; k < PATTERN_COUNT; k++) begin
            if (PAT_CARE[k][idx] && data != PAT_DATA[k][idx]) begin
               res[k] = 1'b0;
            end
         end
      end
      return res;
   endfunction

   // Lowest-numbered live pattern.
   function automatic logic [KIND_W-1:0] first_alive(input logic [PATTERN_COUNT-1:0] alive);
      logic [KIND_W-1:0] res;
      res = '0;
      for (int k = PATTERN_COUNT - 1; k >= 0; k--) begin
         if (alive[k]) begin
            res = KIND_W'(k);
         end
      end
      return res;
   endfunction

endpackage

/* hw/rtl/adv_pattern_classifier_tracker_core.sv */
// ----------------------------------------------------------------------------
// adv_pattern_classifier_tracker_core
// Masked pattern classifier for advertisement payloads with an aging device table.
// ----------------------------------------------------------------------------
// A payload byte that is not the last one is absorbed in the cycle it is
// accepted and gives no result; busy stays low. A last byte that matches no
// pattern gives its result in the following cycle, also without busy. A
// matched last byte and an aging sweep each walk the 16-entry device table
// through its single read port, one entry per cycle, with busy high for the
// walk and, for a matched byte, for the update state ST_FINISH after it;
// rsp_strobe pulses in the first cycle after busy drops. The receiver cannot
// stall; rsp_strobe is high for exactly one cycle per result. The table needs
// no clearing pass after reset; csr_ready is always high.
module adv_pattern_classifier_tracker_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  apct_pkg::req_type req_item,
   output logic              rsp_strobe,
   output apct_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);

   `include "adv_pattern_classifier_tracker_core_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOKUP = 4'b0010,
      ST_SWEEP  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                             state_ff, state_in;
   logic [apct_pkg::POS_W-1:0]            pos_ff, pos_in;
   logic [apct_pkg::PATTERN_COUNT-1:0]    alive_ff, alive_in;
   logic [apct_pkg::TABLE_ENTRIES-1:0]    valid_ff, valid_in;
   logic [apct_pkg::CNT_W-1:0]            occ_ff, occ_in;
   logic [31:0]                           age_limit_ff;
   logic [apct_pkg::CNT_W-1:0]            ptr_ff, ptr_in;
   logic                                  chk_vld_ff, chk_vld_in;
   logic [apct_pkg::IDX_W-1:0]            chk_idx_ff, chk_idx_in;
   logic                                  hit_fnd_ff, hit_fnd_in;
   logic [apct_pkg::IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic [apct_pkg::KIND_W-1:0]           hit_kind_ff, hit_kind_in;
   logic                                  free_fnd_ff, free_fnd_in;
   logic [apct_pkg::IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic [apct_pkg::CNT_W-1:0]            removed_ff, removed_in;
   apct_pkg::entry_type                   work_ff, work_in;
   logic                                  rsp_strobe_ff, rsp_strobe_in;
   apct_pkg::rsp_type                     rsp_ff, rsp_in;

   logic                                  rd_en;
   logic [apct_pkg::IDX_W-1:0]            rd_addr;
   apct_pkg::entry_type                   rd_data;
   logic                                  wr_en;
   logic [apct_pkg::IDX_W-1:0]            wr_addr;
   apct_pkg::entry_type                   wr_data;

   logic                                  accept;
   logic [apct_pkg::PATTERN_COUNT-1:0]    alive_upd;
   logic [apct_pkg::POS_W-1:0]            pos_upd;
   logic                                  adv_match;
   logic                                  walk_end;
   logic                                  chk_live;

   assign accept    = start && !busy;
   assign alive_upd = apct_pkg::alive_update(alive_ff, pos_ff, req_item.data_byte);
   assign pos_upd   = (pos_ff == apct_pkg::POS_MAX) ? pos_ff : pos_ff + 1'b1;
   assign adv_match = (int'(pos_upd) >= apct_pkg::MATCH_LEN) && (|alive_upd);
   assign walk_end  = (ptr_ff == apct_pkg::CNT_W'(apct_pkg::TABLE_ENTRIES));
   assign chk_live  = chk_vld_ff && valid_ff[chk_idx_ff];

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   apct_ram #(
      .WIDTH($bits(apct_pkg::entry_type)),
      .DEPTH(apct_pkg::TABLE_ENTRIES)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      alive_in      = alive_ff;
      valid_in      = valid_ff;
      occ_in        = occ_ff;
      ptr_in        = ptr_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = ptr_ff[apct_pkg::IDX_W-1:0];
      hit_fnd_in    = hit_fnd_ff;
      hit_idx_in    = hit_idx_ff;
      hit_kind_in   = hit_kind_ff;
      free_fnd_in   = free_fnd_ff;
      free_idx_in   = free_idx_ff;
      removed_in    = removed_ff;
      work_in       = work_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[apct_pkg::IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = hit_idx_ff;
      wr_data       = work_ff;

      unique case (state_ff)
         ST_IDLE: begin
            ptr_in      = '0;
            hit_fnd_in  = 1'b0;
            free_fnd_in = 1'b0;
            removed_in  = '0;
            if (accept) begin
               work_in.seen = req_item.now_ms;
               if (req_item.mode) begin
                  state_in = ST_SWEEP;
               end else begin
                  alive_in = alive_upd;
                  pos_in   = pos_upd;
                  if (req_item.last) begin
                     // The next advertisement starts from a clean slate.
                     alive_in         = '1;
                     pos_in           = '0;
                     work_in.address  = req_item.address;
                     work_in.strength = req_item.signal_strength;
                     work_in.kind     = apct_pkg::first_alive(alive_upd);
                     if (adv_match) begin
                        state_in = ST_LOOKUP;
                     end else begin
                        rsp_strobe_in    = 1'b1;
                        rsp_in           = '0;
                        rsp_in.action    = apct_pkg::ACT_NONE;
                        rsp_in.occupancy = apct_pkg::COUNT_W'(occ_ff);
                     end
                  end
               end
            end
         end

         ST_LOOKUP, ST_SWEEP: begin
            // Reads are issued one entry ahead of the compare stage.
            if (!walk_end) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               ptr_in     = ptr_ff + 1'b1;
            end
            if (state_ff == ST_LOOKUP) begin
               if (chk_live && !hit_fnd_ff && rd_data.address == work_ff.address) begin
                  hit_fnd_in  = 1'b1;
                  hit_idx_in  = chk_idx_ff;
                  hit_kind_in = rd_data.kind;
               end
               if (chk_vld_ff && !valid_ff[chk_idx_ff] && !free_fnd_ff) begin
                  free_fnd_in = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (walk_end) begin
                  state_in = ST_FINISH;
               end
            end else begin
               if (chk_live && (work_ff.seen - rd_data.seen) > age_limit_ff) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  removed_in           = removed_ff + 1'b1;
                  occ_in               = occ_ff - 1'b1;
               end
               if (walk_end) begin
                  state_in         = ST_IDLE;
                  rsp_strobe_in    = 1'b1;
                  rsp_in           = '0;
                  rsp_in.action    = apct_pkg::ACT_NONE;
                  rsp_in.removed   = apct_pkg::COUNT_W'(removed_in);
                  rsp_in.occupancy = apct_pkg::COUNT_W'(occ_in);
               end
            end
         end

         ST_FINISH: begin
            state_in       = ST_IDLE;
            rsp_strobe_in  = 1'b1;
            rsp_in         = '0;
            rsp_in.matched = 1'b1;
            rsp_in.kind    = work_ff.kind;
            priority if (hit_fnd_ff) begin
               // A refresh keeps the kind recorded at insertion.
               wr_en        = 1'b1;
               wr_addr      = hit_idx_ff;
               wr_data.kind = hit_kind_ff;
               rsp_in.action = apct_pkg::ACT_REFRESH;
               rsp_in.slot   = apct_pkg::SLOT_W'(hit_idx_ff);
            end else if (free_fnd_ff) begin
               wr_en                 = 1'b1;
               wr_addr               = free_idx_ff;
               valid_in[free_idx_ff] = 1'b1;
               occ_in                = occ_ff + 1'b1;
               rsp_in.action         = apct_pkg::ACT_INSERT;
               rsp_in.slot           = apct_pkg::SLOT_W'(free_idx_ff);
            end else begin
               rsp_in.action = apct_pkg::ACT_DROP;
            end
            rsp_in.occupancy = apct_pkg::COUNT_W'(occ_in);
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         alive_ff      <= '1;
         valid_ff      <= '0;
         occ_ff        <= '0;
         age_limit_ff  <= apct_pkg::AGE_RESET;
         ptr_ff        <= '0;
         chk_vld_ff    <= 1'b0;
         hit_fnd_ff    <= 1'b0;
         free_fnd_ff   <= 1'b0;
         removed_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         alive_ff      <= alive_in;
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
         ptr_ff        <= ptr_in;
         chk_vld_ff    <= chk_vld_in;
         hit_fnd_ff    <= hit_fnd_in;
         free_fnd_ff   <= free_fnd_in;
         removed_ff    <= removed_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            age_limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_kind_ff <= hit_kind_in;
      free_idx_ff <= free_idx_in;
      work_ff     <= work_in;
      rsp_ff      <= rsp_in;
   end

   `APCT_ASSERT_SAME(a_occ_matches_valid, 1'b1,
      occ_ff == apct_pkg::CNT_W'($countones(valid_ff)),
      "Occupancy count disagrees with the valid bits.")
   `APCT_ASSERT_SAME(a_unmatched_quiet, rsp_strobe_ff && !rsp_ff.matched,
      rsp_ff.kind == '0 && rsp_ff.action == apct_pkg::ACT_NONE && rsp_ff.slot == '0,
      "Unmatched transaction reports a table action.")
   `APCT_ASSERT_NEXT(a_finish_reports, state_ff == ST_FINISH,
      rsp_strobe_ff && state_ff == ST_IDLE,
      "Table update did not produce its result.")
   `APCT_ASSERT_NEXT(a_sweep_goes_busy, accept && req_item.mode, busy,
      "Sweep transaction did not start the table walk.")
   `APCT_ASSERT_SAME(a_no_read_on_write, wr_en, !rd_en,
      "Entry memory read and written in the same cycle.")

endmodule

/* hw/rtl/apct_ram.sv */
// ----------------------------------------------------------------------------
// apct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module apct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
